FILE: design/sensor_rms_and_trend_predictor_core_assert.svh
// Assertion macros shared by the sensor trend core modules.
// Expects clk and arst_n in the scope of each use.
`ifndef SENSOR_RMS_AND_TREND_PREDICTOR_CORE_ASSERT_SVH
`define SENSOR_RMS_AND_TREND_PREDICTOR_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define SRTP_ASSERT_IMPL(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define SRTP_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: design/srtp_pkg.sv
// Shared types and constants for the sensor trend core.
// No dependencies.
package srtp_pkg;

	// Default depth of the temperature window
	localparam int WINDOW_DEF = 16;

	// 25 C in 8.8 fixed point, the ring and held value after reset
	localparam logic signed [15:0] TEMP_RESET = 16'sd6400;

	// Offset that makes the window sum nonnegative before division
	localparam int BIAS = 32768;

	// Entries of the queue between front and back
	localparam int QDEPTH = 2;

	// One sample word after the held values are settled
	typedef struct packed {
		logic signed [15:0] temp;
		logic [14:0]        humidity;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
	} srtp_item_t;

endpackage

FILE: design/srtp_front.sv
// Front end: accepts sample words and resolves the held readings.
// Depends on srtp_pkg.
module srtp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               temp_valid,
	input  logic signed [15:0] temperature,
	input  logic               humid_valid,
	input  logic [14:0]        humidity,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	output logic               push_valid,
	input  logic               push_ready,
	output srtp_pkg::srtp_item_t push_item
);
	import srtp_pkg::*;

	logic signed [15:0] last_temp_q;
	logic [14:0]        last_hum_q;
	logic               accept;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid && push_ready;

	// Take the new reading if it is good, else keep the last one
	always_comb begin
		push_item.temp     = temp_valid ? temperature : last_temp_q;
		push_item.humidity = humid_valid ? humidity : last_hum_q;
		push_item.ax       = accel_x;
		push_item.ay       = accel_y;
		push_item.az       = accel_z;
	end

	// Hold the last good readings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_temp_q <= TEMP_RESET;
			last_hum_q  <= '0;
		end else if (accept) begin
			last_temp_q <= push_item.temp;
			last_hum_q  <= push_item.humidity;
		end
	end

endmodule

FILE: design/srtp_queue.sv
// Short queue of sample words between front and back.
// Depends on srtp_pkg and the assertion header.
module srtp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_valid,
	output logic                 wr_ready,
	input  srtp_pkg::srtp_item_t wr_item,
	output logic                 rd_valid,
	input  logic                 rd_ready,
	output srtp_pkg::srtp_item_t rd_item
);
	import srtp_pkg::*;
	`include "sensor_rms_and_trend_predictor_core_assert.svh"

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	srtp_item_t      slot_q [QDEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [CW-1:0]   cnt_q;
	logic            push;
	logic            pop;

	assign wr_ready = (cnt_q != CW'(QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_item  = slot_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= wr_item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`SRTP_ASSERT_IMPL(a_q_bound, 1'b1, cnt_q <= CW'(QDEPTH), "queue count beyond depth")
	`SRTP_ASSERT_NEXT(a_q_fill, push && !pop, cnt_q != '0, "queue empty after a push")
	`SRTP_ASSERT_NEXT(a_q_room, pop && !push, cnt_q != CW'(QDEPTH), "queue full after a pop")

endmodule

FILE: design/srtp_back.sv
// Back end: temperature ring, window mean, trend and acceleration RMS.
// Depends on srtp_pkg and the assertion header.
module srtp_back #(
	parameter int WINDOW = srtp_pkg::WINDOW_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  srtp_pkg::srtp_item_t q_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [15:0]   held_temp,
	output logic [14:0]          held_humidity,
	output logic signed [15:0]   window_mean,
	output logic signed [15:0]   predicted_temp,
	output logic [14:0]          accel_rms
);
	import srtp_pkg::*;
	`include "sensor_rms_and_trend_predictor_core_assert.svh"

	localparam int LW = $clog2(WINDOW);
	localparam int SW = 16 + LW;
	localparam int DW = 16 + LW;
	localparam int PW = 2 * DW + 1;
	localparam int DIV_SH = DW + LW;
	localparam logic signed [SW-1:0] SUM_RESET = SW'(6400 * WINDOW);
	localparam logic [DW-1:0] BIAS_W = DW'(BIAS * WINDOW);
	// Rounded-up reciprocals: exact floor quotients over the full operand range
	localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;
	localparam logic [DW:0] RECIP_W =
		(DW + 1)'(((longint'(1) << DIV_SH) + longint'(WINDOW) - 1) / longint'(WINDOW));

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_READ  = 6'b000010,
		ST_SUM   = 6'b000100,
		ST_SCALE = 6'b001000,
		ST_ITER  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t               state_q;
	logic [3:0]           cnt_q;
	logic [LW-1:0]        slot_q;
	logic [WINDOW-1:0]    vld_q;
	logic signed [SW-1:0] sum_q;
	logic                 out_valid_q;

	logic signed [15:0]   mem [WINDOW];
	srtp_item_t           item_q;
	logic signed [15:0]   rdata_q;
	logic                 old_vld_q;
	logic [30:0]          sx_q;
	logic [30:0]          sy_q;
	logic [30:0]          sz_q;
	logic [31:0]          sq_q;
	logic [DW-1:0]        bsum_q;
	logic [17:0]          srem_q;
	logic [15:0]          root_q;
	logic [15:0]          dq_q;

	logic signed [15:0]   held_temp_q;
	logic [14:0]          held_hum_q;
	logic signed [15:0]   mean_q;
	logic signed [15:0]   pred_q;
	logic [14:0]          rms_q;

	logic                 pop;
	logic                 load_out;
	logic signed [15:0]   old_temp;
	logic signed [SW-1:0] sum_next;
	logic [DW-1:0]        biased;
	logic signed [31:0]   px;
	logic signed [31:0]   py;
	logic signed [31:0]   pz;
	logic [30:0]          sq3;
	logic [15:0]          wq;
	logic [19:0]          s_tmp;
	logic [19:0]          s_trial;
	logic                 s_ge;
	logic signed [15:0]   mean_w;
	logic signed [18:0]   h19;
	logic signed [18:0]   m19;
	logic signed [18:0]   pred_w;

	assign pop      = (state_q == ST_IDLE) && q_valid;
	assign q_ready  = (state_q == ST_IDLE);
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// Ring update and squared axes
	always_comb begin
		old_temp = old_vld_q ? rdata_q : TEMP_RESET;
		sum_next = sum_q + SW'(item_q.temp) - SW'(old_temp);
		biased   = $unsigned(sum_q) + BIAS_W;
		px       = item_q.ax * item_q.ax;
		py       = item_q.ay * item_q.ay;
		pz       = item_q.az * item_q.az;
	end

	// Scale by the reciprocals of three and of the window depth
	always_comb begin
		sq3 = 31'((64'(sq_q) * 64'(RECIP3)) >> 33);
		wq  = 16'((PW'(bsum_q) * PW'(RECIP_W)) >> DIV_SH);
	end

	// One step of the square root, two radicand bits per step
	always_comb begin
		s_tmp   = {srem_q, sq_q[31:30]};
		s_trial = {2'b00, root_q, 2'b01};
		s_ge    = (s_tmp >= s_trial);
	end

	// Mean from the offset quotient, then the saturated trend
	always_comb begin
		mean_w = {~dq_q[15], dq_q[14:0]};
		h19    = 19'(item_q.temp);
		m19    = 19'(mean_w);
		pred_w = (h19 <<< 1) + h19 - (m19 <<< 1);
	end

	// Control: sequence, ring slot, valid bits, running sum, output flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			slot_q      <= '0;
			vld_q       <= '0;
			sum_q       <= SUM_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					sum_q         <= sum_next;
					vld_q[slot_q] <= 1'b1;
					slot_q        <= (slot_q == LW'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
					state_q       <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					cnt_q   <= '0;
					state_q <= ST_ITER;
				end
				ST_ITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'd15) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Ring memory: read at pop, write back in the following cycle
	always_ff @(posedge clk) begin
		if (pop) begin
			rdata_q <= mem[slot_q];
		end
		if (state_q == ST_READ) begin
			mem[slot_q] <= item_q.temp;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			item_q    <= q_item;
			old_vld_q <= vld_q[slot_q];
		end
		if (state_q == ST_READ) begin
			sx_q <= px[30:0];
			sy_q <= py[30:0];
			sz_q <= pz[30:0];
		end
		if (state_q == ST_SUM) begin
			sq_q   <= 32'(sx_q) + 32'(sy_q) + 32'(sz_q);
			bsum_q <= biased;
		end
		if (state_q == ST_SCALE) begin
			sq_q   <= {1'b0, sq3};
			dq_q   <= wq;
			srem_q <= '0;
			root_q <= '0;
		end
		if (state_q == ST_ITER) begin
			sq_q <= {sq_q[29:0], 2'b00};
			if (s_ge) begin
				srem_q <= 18'(s_tmp - s_trial);
				root_q <= {root_q[14:0], 1'b1};
			end else begin
				srem_q <= s_tmp[17:0];
				root_q <= {root_q[14:0], 1'b0};
			end
		end
		if (load_out) begin
			held_temp_q <= item_q.temp;
			held_hum_q  <= item_q.humidity;
			mean_q      <= mean_w;
			if (pred_w > 19'sd32767) begin
				pred_q <= 16'sh7FFF;
			end else if (pred_w < -19'sd32768) begin
				pred_q <= 16'sh8000;
			end else begin
				pred_q <= pred_w[15:0];
			end
			rms_q <= root_q[15] ? 15'h7FFF : root_q[14:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign held_temp      = held_temp_q;
	assign held_humidity  = held_hum_q;
	assign window_mean    = mean_q;
	assign predicted_temp = pred_q;
	assign accel_rms      = rms_q;

	`SRTP_ASSERT_NEXT(a_done_loads, load_out, out_valid_q, "result not registered")
	`SRTP_ASSERT_NEXT(a_iter_ends, (state_q == ST_ITER) && (cnt_q == 4'd15), state_q == ST_DONE, "root loop overran")
	`SRTP_ASSERT_NEXT(a_scale_iter, state_q == ST_SCALE, state_q == ST_ITER, "scaling step not followed by the root loop")
	`SRTP_ASSERT_IMPL(a_sqrt_rem, state_q == ST_ITER, srem_q <= {1'b0, root_q, 1'b0}, "root remainder too large")

endmodule

FILE: design/sensor_rms_and_trend_predictor_core.sv
// Each accepted word goes through the queue into the back end, which reads the ring,
// writes it back and updates the sum, sums the squared axes, scales by the reciprocals,
// runs the 16-step square root loop and hands over; it takes no new word until then.
// A two-word queue lets the front take words while the back is busy.
// Reset: asynchronous, clears the ring valid bits so every entry reads 25 C,
// sets the running sum and held values; no clearing pass is needed.
module sensor_rms_and_trend_predictor_core #(
	parameter int WINDOW = srtp_pkg::WINDOW_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               temp_valid,
	input  logic signed [15:0] temperature,
	input  logic               humid_valid,
	input  logic [14:0]        humidity,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] held_temp,
	output logic [14:0]        held_humidity,
	output logic signed [15:0] window_mean,
	output logic signed [15:0] predicted_temp,
	output logic [14:0]        accel_rms
);
	import srtp_pkg::*;

	logic       push_valid;
	logic       push_ready;
	srtp_item_t push_item;
	logic       q_valid;
	logic       q_ready;
	srtp_item_t q_item;

	// Accept and settle held readings
	srtp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.temp_valid  (temp_valid),
		.temperature (temperature),
		.humid_valid (humid_valid),
		.humidity    (humidity),
		.accel_x     (accel_x),
		.accel_y     (accel_y),
		.accel_z     (accel_z),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_item   (push_item)
	);

	// Decouple front from back
	srtp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_item  (push_item),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_item  (q_item)
	);

	// Ring, mean, trend and RMS
	srtp_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_ready        (q_ready),
		.q_item         (q_item),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.held_temp      (held_temp),
		.held_humidity  (held_humidity),
		.window_mean    (window_mean),
		.predicted_temp (predicted_temp),
		.accel_rms      (accel_rms)
	);

endmodule

FILE: bench/sensor_rms_and_trend_predictor_core_tb.sv
// Self-checking bench for the sensor trend core: a directed table, then random words.
// Depends on srtp_pkg and sensor_rms_and_trend_predictor_core; each result is checked
// against a trend predictor held in this file, or against typed-in values for three rows.
module sensor_rms_and_trend_predictor_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import srtp_pkg::*;

	localparam int WIN = WINDOW_DEF;
	localparam int RAND_WORDS = 1000;
	localparam int DIR_ROWS = 20;
	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 800;

	// One sample word as driven on the input ports
	typedef struct packed {
		logic               tv;
		logic signed [15:0] t;
		logic               hv;
		logic [14:0]        h;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
	} sample_t;

	// One result word as seen on the output ports
	typedef struct packed {
		logic signed [15:0] held_t;
		logic [14:0]        held_h;
		logic signed [15:0] mean;
		logic signed [15:0] pred;
		logic [14:0]        rms;
	} trend_t;

	typedef struct packed {
		sample_t smp;
		logic    known;
		trend_t  res;
	} dir_row_t;

	localparam trend_t NO_RES = '0;

	// Directed words; the first three start from reset, so their results are typed in
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		'{'{1'b0, 16'sd0, 1'b0, 15'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
			'{16'sd6400, 15'd0, 16'sd6400, 16'sd6400, 15'd0}},
		'{'{1'b0, 16'sh7FFF, 1'b0, 15'h7FFF, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b1,
			'{16'sd6400, 15'd0, 16'sd6400, 16'sd6400, 15'h7FFF}},
		'{'{1'b1, 16'sd6400, 1'b1, 15'h7FFF, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
			'{16'sd6400, 15'h7FFF, 16'sd6400, 16'sd6400, 15'd0}},
		'{'{1'b1, 16'sd20480, 1'b1, 15'd25600, 16'sd20096, 16'sd20096, 16'sd20096},
			1'b0, NO_RES},
		'{'{1'b1, -16'sd10240, 1'b1, 15'd0, -16'sd20096, -16'sd20096, -16'sd20096},
			1'b0, NO_RES},
		'{'{1'b1, 16'sh7FFF, 1'b0, 15'd100, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b0, NO_RES},
		'{'{1'b1, 16'sh8000, 1'b1, 15'd12800, 16'sh8000, 16'sd0, 16'sh7FFF}, 1'b0, NO_RES},
		'{'{1'b0, 16'sd1234, 1'b0, 15'h5555, 16'sd1, -16'sd1, 16'sd1}, 1'b0, NO_RES},
		'{'{1'b1, -16'sd10240, 1'b1, 15'd25600, 16'sd20096, -16'sd20096, 16'sd0},
			1'b0, NO_RES},
		'{'{1'b1, -16'sd10240, 1'b1, 15'd25600, 16'sd0, 16'sd20096, -16'sd20096},
			1'b0, NO_RES},
		'{'{1'b1, -16'sd10240, 1'b0, 15'd0, 16'sd256, 16'sd512, 16'sd768}, 1'b0, NO_RES},
		'{'{1'b1, -16'sd10240, 1'b1, 15'd3, -16'sd256, 16'sd0, 16'sd0}, 1'b0, NO_RES},
		'{'{1'b1, -16'sd10240, 1'b1, 15'd25599, 16'sd3, 16'sd4, 16'sd5}, 1'b0, NO_RES},
		'{'{1'b1, -16'sd10240, 1'b0, 15'd0, 16'sd10000, -16'sd10000, 16'sd10000},
			1'b0, NO_RES},
		'{'{1'b0, 16'sh5555, 1'b0, 15'h2AAA, 16'sh5555, 16'shAAAA, 16'sh5555}, 1'b0, NO_RES},
		'{'{1'b1, -16'sd1, 1'b0, 15'd0, -16'sd1, -16'sd1, -16'sd1}, 1'b0, NO_RES},
		'{'{1'b1, 16'sd0, 1'b1, 15'h2AAA, 16'sh5555, 16'shAAAA, 16'sd0}, 1'b0, NO_RES},
		'{'{1'b1, 16'sd20480, 1'b1, 15'd1, 16'sd255, 16'sd256, 16'sd257}, 1'b0, NO_RES},
		'{'{1'b0, 16'sd0, 1'b1, 15'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, NO_RES},
		'{'{1'b1, -16'sd10240, 1'b1, 15'h7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF}, 1'b0, NO_RES}
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               temp_valid;
	logic signed [15:0] temperature;
	logic               humid_valid;
	logic [14:0]        humidity;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] held_temp;
	logic [14:0]        held_humidity;
	logic signed [15:0] window_mean;
	logic signed [15:0] predicted_temp;
	logic [14:0]        accel_rms;

	// Predictor state
	logic signed [15:0] temp_win [WIN];
	int                 win_slot;
	longint             win_sum;
	logic signed [15:0] hold_t;
	logic [14:0]        hold_h;

	trend_t pending_trends [$];
	int     words_in = 0;
	int     fail_cnt = 0;
	int     burst_left = 0;
	int     walk_temp = 6400;
	int     cycle_cnt = 0;

	sensor_rms_and_trend_predictor_core #(
		.WINDOW(WIN)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.temp_valid    (temp_valid),
		.temperature   (temperature),
		.humid_valid   (humid_valid),
		.humidity      (humidity),
		.accel_x       (accel_x),
		.accel_y       (accel_y),
		.accel_z       (accel_z),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.held_temp     (held_temp),
		.held_humidity (held_humidity),
		.window_mean   (window_mean),
		.predicted_temp(predicted_temp),
		.accel_rms     (accel_rms)
	);

	always #5 clk = ~clk;

	// Floor square root, one result bit per pass
	function automatic longint floor_root(input longint v);
		longint rem;
		longint root;
		longint bitv;
		rem = v;
		root = 0;
		bitv = longint'(1) << 62;
		while (bitv > rem)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem = rem - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// Advance the held values and the window, then work out the result word
	function automatic trend_t predict_trend(input sample_t s);
		trend_t r;
		longint m;
		longint p;
		longint sq;
		longint root;
		if (s.tv)
			hold_t = s.t;
		if (s.hv)
			hold_h = s.h;
		win_sum = win_sum + longint'(hold_t) - longint'(temp_win[win_slot]);
		temp_win[win_slot] = hold_t;
		win_slot = (win_slot + 1) % WIN;
		// bias the sum so the division floors toward minus infinity
		m = (win_sum + longint'(BIAS) * WIN) / WIN - BIAS;
		p = 3 * longint'(hold_t) - 2 * m;
		if (p > 32767)
			p = 32767;
		if (p < -32768)
			p = -32768;
		sq = longint'(s.ax) * longint'(s.ax) + longint'(s.ay) * longint'(s.ay)
			+ longint'(s.az) * longint'(s.az);
		root = floor_root(sq / 3);
		if (root > 32767)
			root = 32767;
		r.held_t = hold_t;
		r.held_h = hold_h;
		r.mean = 16'(m);
		r.pred = 16'(p);
		r.rms = 15'(root);
		return r;
	endfunction

	function automatic logic signed [15:0] draw_axis();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 85)
			return 16'(int'($urandom_range(0, 40192)) - 20096);
		else if (pick < 93)
			return 16'($urandom);
		case ($urandom_range(0, 4))
			0: return -16'sd20096;
			1: return 16'sd20096;
			2: return 16'sh8000;
			3: return 16'sh7FFF;
			default: return 16'sd0;
		endcase
	endfunction

	// Mostly a drifting temperature, with some jumps, raw patterns and extremes
	function automatic sample_t draw_sample();
		sample_t s;
		int pick;
		s.tv = ($urandom_range(0, 9) != 0);
		s.hv = ($urandom_range(0, 9) != 0);
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			walk_temp = walk_temp + int'($urandom_range(0, 1200)) - 600;
			if (walk_temp > 20480)
				walk_temp = 20480;
			if (walk_temp < -10240)
				walk_temp = -10240;
			s.t = 16'(walk_temp);
		end else if (pick < 8) begin
			s.t = 16'(int'($urandom_range(0, 30720)) - 10240);
		end else if (pick == 8) begin
			s.t = 16'($urandom);
		end else begin
			case ($urandom_range(0, 3))
				0: s.t = -16'sd10240;
				1: s.t = 16'sd20480;
				2: s.t = 16'sh7FFF;
				default: s.t = 16'sh8000;
			endcase
		end
		pick = $urandom_range(0, 19);
		if (pick < 17)
			s.h = 15'($urandom_range(0, 25600));
		else if (pick < 19)
			s.h = 15'($urandom);
		else
			s.h = ($urandom_range(0, 1) != 0) ? 15'd25600 : 15'd0;
		s.ax = draw_axis();
		s.ay = draw_axis();
		s.az = draw_axis();
		return s;
	endfunction

	// Idle between bursts of words; some bursts run long with no gap at all
	task automatic pace();
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					gap = 0;
					burst_left = 40;
				end
				2: begin
					gap = $urandom_range(20, 60);
					burst_left = $urandom_range(1, 16);
				end
				default: begin
					gap = $urandom_range(1, 6);
					burst_left = $urandom_range(1, 16);
				end
			endcase
		end
		burst_left--;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Offer one word, hold it until taken, then queue what it should give
	task automatic offer_word(input sample_t s, input logic known, input trend_t typed);
		trend_t p;
		@(negedge clk);
		in_valid    <= 1'b1;
		temp_valid  <= s.tv;
		temperature <= s.t;
		humid_valid <= s.hv;
		humidity    <= s.h;
		accel_x     <= s.ax;
		accel_y     <= s.ay;
		accel_z     <= s.az;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		p = predict_trend(s);
		pending_trends.push_back(known ? typed : p);
		words_in++;
	endtask

	// Drop valid and hold until every queued result has come back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_trends.size() != 0)
			@(negedge clk);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_cnt++;
		end
	endtask

	// Sender
	initial begin
		sample_t s;
		int i;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		temp_valid  = 1'b0;
		temperature = '0;
		humid_valid = 1'b0;
		humidity    = '0;
		accel_x     = '0;
		accel_y     = '0;
		accel_z     = '0;
		for (i = 0; i < WIN; i++)
			temp_win[i] = TEMP_RESET;
		win_slot = 0;
		win_sum = longint'(TEMP_RESET) * WIN;
		hold_t = TEMP_RESET;
		hold_h = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		foreach (DIR_TAB[k]) begin
			pace();
			offer_word(DIR_TAB[k].smp, DIR_TAB[k].known, DIR_TAB[k].res);
		end

		for (i = 0; i < RAND_WORDS; i++) begin
			// halfway, let the block run dry before going on
			if (i == RAND_WORDS / 2)
				wait_drained();
			pace();
			s = draw_sample();
			offer_word(s, 1'b0, NO_RES);
		end

		wait_drained();
		repeat (40) @(negedge clk);
		if (fail_cnt == 0)
			$display("sensor_rms_and_trend_predictor_core_tb: PASS");
		else
			$display("sensor_rms_and_trend_predictor_core_tb: FAIL");
		$finish;
	end

	// Receiver: changing stall patterns, and one long hold-off to back the block up
	initial begin
		int mode;
		int span;
		int phase;
		int hold;
		bit held_off;
		out_ready = 1'b0;
		mode = 0;
		span = 0;
		phase = 0;
		held_off = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_off && words_in >= 200) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				for (hold = 0; hold < HOLD_CYCLES; hold++)
					@(negedge clk);
			end
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(16, 128);
			end
			span--;
			phase++;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) != 0);
				2: out_ready <= ((phase % 4) == 0);
				default: out_ready <= ($urandom_range(0, 4) != 0);
			endcase
		end
	end

	// Compare each result word with the oldest expectation
	always @(posedge clk) begin
		trend_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_trends.size() == 0) begin
				$error("result word with nothing expected");
				fail_cnt++;
			end else begin
				want = pending_trends.pop_front();
				check_field("held_temp", int'(want.held_t), int'(held_temp));
				check_field("held_humidity", int'(want.held_h), int'(held_humidity));
				check_field("window_mean", int'(want.mean), int'(window_mean));
				check_field("predicted_temp", int'(want.pred), int'(predicted_temp));
				check_field("accel_rms", int'(want.rms), int'(accel_rms));
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("sensor_rms_and_trend_predictor_core_tb: FAIL");
			$finish;
		end
	end

endmodule

FILE: sim.f
+incdir+design
design/srtp_pkg.sv
design/srtp_front.sv
design/srtp_queue.sv
design/srtp_back.sv
design/sensor_rms_and_trend_predictor_core.sv
bench/sensor_rms_and_trend_predictor_core_tb.sv
